>>> sv/sparse_gather_mac_scale_defines.svh
// ----------------------------------------------------------------------------
// Sparse gather MAC scale: assertion macros
// Shared property forms for the checks written at the end of the modules.
// ----------------------------------------------------------------------------
`ifndef SPARSE_GATHER_MAC_SCALE_DEFINES_SVH
`define SPARSE_GATHER_MAC_SCALE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SGMS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SGMS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/sgms_pkg.sv
// ----------------------------------------------------------------------------
// Sparse gather MAC scale package
// Transaction types, command encoding, back end states and saturation limits.
// ----------------------------------------------------------------------------
package sgms_pkg;

    typedef enum logic [1:0] {
        OP_WR_TABLE  = 2'd0,
        OP_WR_RESULT = 2'd1,
        OP_TERM      = 2'd2,
        OP_READ      = 2'd3
    } op_t;

    typedef struct packed {
        logic [1:0]         operation;
        logic [11:0]        table_address;
        logic [9:0]         result_index;
        logic signed [31:0] data_value;
        logic signed [31:0] coefficient;
        logic               last_term;
    } in_item_t;

    typedef struct packed {
        logic [9:0]         out_index;
        logic signed [31:0] out_value;
        logic               overflow;
    } out_item_t;

    typedef struct packed {
        op_t                op;
        logic [11:0]        table_address;
        logic [9:0]         result_index;
        logic signed [31:0] data_value;
        logic signed [31:0] coefficient;
        logic               last_term;
        logic               t_ok;
        logic               r_ok;
    } cmd_t;

    typedef enum logic [2:0] {
        ST_FETCH,
        ST_MUL,
        ST_ADD,
        ST_PLO,
        ST_PHI,
        ST_COMB,
        ST_SCALE_OUT,
        ST_READ_OUT
    } state_t;

    localparam int CMD_DEPTH = 4;
    localparam int OUT_DEPTH = 2;

    localparam logic signed [63:0] SUM_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] SUM_MIN = 64'sh8000_0000_0000_0000;
    localparam logic signed [31:0] VAL_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;

endpackage

>>> sv/sparse_gather_mac_scale.sv
// ----------------------------------------------------------------------------
// Sparse gather MAC scale top level
// Decoupled front end and back end joined by a command queue; results leave
// through a small output queue.
// ----------------------------------------------------------------------------
// Flow: an accepted item is registered in the front end, passes the command
// queue and is fetched by the back end; table and result writes reach the
// stores as they are fetched. A read returns the registered store data; a
// last term passes the multiply, add, partial product, combine and scale
// states. The back end finishes one command before it fetches the next.
// Reset clears the queues, the sequencer and the running sum; both stores
// hold unknown contents until written.
module sparse_gather_mac_scale
    import sgms_pkg::*;
#(
    parameter int TABLE_DEPTH  = 4096,
    parameter int RESULT_DEPTH = 1024
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    output logic      full,
    input  in_item_t  item,
    output logic      empty,
    input  logic      pop,
    output out_item_t result
);

    logic      cq_push;
    cmd_t      cq_wdata;
    logic      cq_full;
    logic      cq_pop;
    cmd_t      cq_rdata;
    logic      cq_empty;
    logic      rq_push;
    out_item_t rq_wdata;
    logic      rq_full;

    sgms_front #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .RESULT_DEPTH(RESULT_DEPTH)
    ) u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .item  (item),
        .full  (full),
        .q_push(cq_push),
        .q_data(cq_wdata),
        .q_full(cq_full)
    );

    sgms_fifo #(
        .W    ($bits(cmd_t)),
        .DEPTH(CMD_DEPTH)
    ) u_cmd_q (
        .clk  (clk),
        .rst_n(rst_n),
        .push (cq_push),
        .wdata(cq_wdata),
        .full (cq_full),
        .pop  (cq_pop),
        .rdata(cq_rdata),
        .empty(cq_empty)
    );

    sgms_back #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .RESULT_DEPTH(RESULT_DEPTH)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (cq_empty),
        .q_data  (cq_rdata),
        .q_pop   (cq_pop),
        .res_full(rq_full),
        .res_push(rq_push),
        .res_data(rq_wdata)
    );

    sgms_fifo #(
        .W    ($bits(out_item_t)),
        .DEPTH(OUT_DEPTH)
    ) u_res_q (
        .clk  (clk),
        .rst_n(rst_n),
        .push (rq_push),
        .wdata(rq_wdata),
        .full (rq_full),
        .pop  (pop),
        .rdata(result),
        .empty(empty)
    );

endmodule

>>> sv/sgms_fifo.sv
// ----------------------------------------------------------------------------
// Sparse gather MAC scale queue
// Small first-in first-out buffer built from flip-flops.
// ----------------------------------------------------------------------------
module sgms_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 4
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] wdata,
    output logic         full,
    input  logic         pop,
    output logic [W-1:0] rdata,
    output logic         empty
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg;
    logic [PW-1:0] rd_ptr_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          do_push;
    logic          do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

>>> sv/sgms_front.sv
// ----------------------------------------------------------------------------
// Sparse gather MAC scale front end
// Accepts input transactions, decodes the operation, checks both addresses
// against the store depths and hands the command to the command queue.
// ----------------------------------------------------------------------------
module sgms_front
    import sgms_pkg::*;
#(
    parameter int TABLE_DEPTH  = 4096,
    parameter int RESULT_DEPTH = 1024
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  in_item_t item,
    output logic     full,
    output logic     q_push,
    output cmd_t     q_data,
    input  logic     q_full
);

    logic valid_reg;
    logic valid_next;
    cmd_t hold_reg;
    cmd_t hold_next;
    cmd_t cls;
    logic accept;

    always_comb
    begin
        cls.op            = op_t'(item.operation);
        cls.table_address = item.table_address;
        cls.result_index  = item.result_index;
        cls.data_value    = item.data_value;
        cls.coefficient   = item.coefficient;
        cls.last_term     = item.last_term;
        cls.t_ok          = (32'(item.table_address) < 32'(TABLE_DEPTH));
        cls.r_ok          = (32'(item.result_index) < 32'(RESULT_DEPTH));
    end

    assign full       = valid_reg && q_full;
    assign accept     = push && !full;
    assign q_push     = valid_reg;
    assign q_data     = hold_reg;
    assign valid_next = accept || (valid_reg && q_full);
    assign hold_next  = accept ? cls : hold_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_reg <= hold_next;
    end

endmodule

>>> sv/sgms_back.sv
// ----------------------------------------------------------------------------
// Sparse gather MAC scale back end
// Holds the data table and the result store, accumulates weighted terms into
// a saturating Q32.32 sum and scales the addressed result at the dial's end.
// ----------------------------------------------------------------------------
`include "sparse_gather_mac_scale_defines.svh"

module sgms_back
    import sgms_pkg::*;
#(
    parameter int TABLE_DEPTH  = 4096,
    parameter int RESULT_DEPTH = 1024
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      q_empty,
    input  cmd_t      q_data,
    output logic      q_pop,
    input  logic      res_full,
    output logic      res_push,
    output out_item_t res_data
);

    localparam int TAW = $clog2(TABLE_DEPTH);
    localparam int RAW = $clog2(RESULT_DEPTH);

    logic signed [31:0] tab_mem [TABLE_DEPTH];
    logic signed [31:0] res_mem [RESULT_DEPTH];

    state_t             state_reg;
    state_t             state_next;
    cmd_t               cur_reg;
    cmd_t               cur_next;
    logic signed [31:0] tab_rdata_reg;
    logic signed [31:0] res_rdata_reg;
    logic signed [63:0] prod_reg;
    logic signed [63:0] prod_next;
    logic               add_pend_reg;
    logic               add_pend_next;
    logic signed [63:0] sum_reg;
    logic signed [63:0] sum_next;
    logic               sum_ovf_reg;
    logic               sum_ovf_next;
    logic signed [64:0] plo_reg;
    logic signed [64:0] plo_next;
    logic signed [63:0] phi_reg;
    logic signed [63:0] phi_next;
    logic signed [63:0] t_reg;
    logic signed [63:0] t_next;

    logic               rd_en;
    logic               tab_we;
    logic               res_we;
    logic [RAW-1:0]     res_wr_idx;
    logic signed [31:0] res_wdata;
    logic signed [31:0] tv;
    logic signed [31:0] rv;
    logic signed [64:0] sum_wide;
    logic signed [64:0] plo_sh;
    logic [16:0]        t_top;
    logic               fits;
    logic signed [31:0] scaled;

    assign tv       = cur_reg.t_ok ? tab_rdata_reg : '0;
    assign rv       = cur_reg.r_ok ? res_rdata_reg : '0;
    assign sum_wide = {sum_reg[63], sum_reg} + {prod_reg[63], prod_reg};
    assign plo_sh   = plo_reg >>> 32;
    assign t_top    = t_reg[63:47];
    assign fits     = (t_top == '0) || (t_top == '1);
    assign scaled   = fits ? t_reg[47:16] : (t_reg[63] ? VAL_MIN : VAL_MAX);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_FETCH:
            begin
                if (!q_empty)
                begin
                    case (q_data.op)
                        OP_TERM: state_next = ST_MUL;
                        OP_READ: state_next = ST_READ_OUT;
                        default: state_next = ST_FETCH;
                    endcase
                end
            end
            ST_MUL:       state_next = cur_reg.last_term ? ST_ADD : ST_FETCH;
            ST_ADD:       state_next = ST_PLO;
            ST_PLO:       state_next = ST_PHI;
            ST_PHI:       state_next = ST_COMB;
            ST_COMB:      state_next = ST_SCALE_OUT;
            ST_SCALE_OUT: state_next = res_full ? ST_SCALE_OUT : ST_FETCH;
            ST_READ_OUT:  state_next = res_full ? ST_READ_OUT : ST_FETCH;
            default:      state_next = ST_FETCH;
        endcase
    end

    always_comb
    begin
        q_pop         = 1'b0;
        rd_en         = 1'b0;
        tab_we        = 1'b0;
        res_we        = 1'b0;
        res_wr_idx    = RAW'(q_data.result_index);
        res_wdata     = q_data.data_value;
        res_push      = 1'b0;
        res_data      = '0;
        cur_next      = cur_reg;
        prod_next     = prod_reg;
        add_pend_next = 1'b0;
        sum_next      = sum_reg;
        sum_ovf_next  = sum_ovf_reg;
        plo_next      = plo_reg;
        phi_next      = phi_reg;
        t_next        = t_reg;

        if (add_pend_reg)
        begin
            if (sum_wide[64] != sum_wide[63])
            begin
                sum_next     = sum_wide[64] ? SUM_MIN : SUM_MAX;
                sum_ovf_next = 1'b1;
            end
            else
            begin
                sum_next = sum_wide[63:0];
            end
        end

        case (state_reg)
            ST_FETCH:
            begin
                if (!q_empty)
                begin
                    q_pop    = 1'b1;
                    rd_en    = 1'b1;
                    cur_next = q_data;
                    tab_we   = (q_data.op == OP_WR_TABLE) && q_data.t_ok;
                    res_we   = (q_data.op == OP_WR_RESULT) && q_data.r_ok;
                end
            end
            ST_MUL:
            begin
                prod_next     = tv * cur_reg.coefficient;
                add_pend_next = 1'b1;
            end
            ST_PLO:
            begin
                plo_next = rv * $signed({1'b0, sum_reg[31:0]});
            end
            ST_PHI:
            begin
                phi_next = rv * $signed(sum_reg[63:32]);
            end
            ST_COMB:
            begin
                t_next = phi_reg + plo_sh[63:0];
            end
            ST_SCALE_OUT:
            begin
                if (!res_full)
                begin
                    res_push           = 1'b1;
                    res_data.out_index = cur_reg.result_index;
                    res_data.out_value = scaled;
                    res_data.overflow  = sum_ovf_reg || !fits;
                    res_we             = cur_reg.r_ok;
                    res_wr_idx         = RAW'(cur_reg.result_index);
                    res_wdata          = scaled;
                    sum_next           = '0;
                    sum_ovf_next       = 1'b0;
                end
            end
            ST_READ_OUT:
            begin
                if (!res_full)
                begin
                    res_push           = 1'b1;
                    res_data.out_index = cur_reg.result_index;
                    res_data.out_value = rv;
                    res_data.overflow  = 1'b0;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_FETCH;
            add_pend_reg <= 1'b0;
            sum_reg      <= '0;
            sum_ovf_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            add_pend_reg <= add_pend_next;
            sum_reg      <= sum_next;
            sum_ovf_reg  <= sum_ovf_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg  <= cur_next;
        prod_reg <= prod_next;
        plo_reg  <= plo_next;
        phi_reg  <= phi_next;
        t_reg    <= t_next;
    end

    always_ff @(posedge clk)
    begin
        if (tab_we)
        begin
            tab_mem[TAW'(q_data.table_address)] <= q_data.data_value;
        end
        if (rd_en)
        begin
            tab_rdata_reg <= tab_mem[TAW'(q_data.table_address)];
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_we)
        begin
            res_mem[res_wr_idx] <= res_wdata;
        end
        if (rd_en)
        begin
            res_rdata_reg <= res_mem[RAW'(q_data.result_index)];
        end
    end

    `SGMS_ASSERT_NOW(a_add_window, clk, rst_n, add_pend_reg,
        (state_reg == ST_FETCH) || (state_reg == ST_ADD),
        "Pending accumulation outside the fetch or add cycle.")
    `SGMS_ASSERT_NEXT(a_sum_cleared, clk, rst_n, (state_reg == ST_SCALE_OUT) && !res_full,
        (sum_reg == '0) && !sum_ovf_reg,
        "Running sum not cleared after the dial completed.")
    `SGMS_ASSERT_NOW(a_push_source, clk, rst_n, res_push,
        (state_reg == ST_SCALE_OUT) || (state_reg == ST_READ_OUT),
        "Result transaction issued from an unexpected state.")

endmodule
